/* sv/gtin_digit_string_validator_core_assert.svh */
// Assertion macros shared by the check-digit validator RTL.
`ifndef GTIN_DIGIT_STRING_VALIDATOR_CORE_ASSERT_SVH
`define GTIN_DIGIT_STRING_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GTIN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define GTIN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gtin_pkg.sv */
// Shared types, codes and prefix range tables for the check-digit validator.
package gtin_pkg;

  localparam int MAX_DIGITS = 14;
  localparam int CNT_W      = 4;
  localparam int SUM_W      = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [7:0] NOT_FOUND = 8'd255;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_CHECK = 2'd3
  } status_t;

  // Format codes; also used to pick the prefix range table.
  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_12 = 2'd1;
  localparam logic [1:0] FMT_13 = 2'd2;
  localparam logic [1:0] FMT_14 = 2'd3;

  typedef logic [3:0] digit_t;

  // Running string state with the current character folded in.
  typedef struct packed {
    digit_t [MAX_DIGITS-1:0] digits;
    logic [CNT_W-1:0]        cnt;
    logic                    bad;
    logic [SUM_W-1:0]        even_sum;
    logic [SUM_W-1:0]        odd_sum;
  } snap_t;

  typedef struct packed {
    logic [1:0]  tbl;
    logic [13:0] lo;
    logic [13:0] hi;
    logic [7:0]  cls;
  } span_t;

  localparam int N_SPANS = 158;

  // Non-overlapping ranges; tbl selects the 8-, 12- or 13/14-digit table.
  localparam span_t SPANS [N_SPANS] = '{
    '{FMT_8, 14'd0, 14'd99, 8'd0}, '{FMT_8, 14'd100, 14'd199, 8'd1},
    '{FMT_8, 14'd200, 14'd299, 8'd0}, '{FMT_8, 14'd300, 14'd951, 8'd1},
    '{FMT_8, 14'd952, 14'd952, 8'd2}, '{FMT_8, 14'd953, 14'd976, 8'd1},
    '{FMT_8, 14'd977, 14'd999, 8'd3},
    '{FMT_12, 14'd1, 14'd1999, 8'd4}, '{FMT_12, 14'd2000, 14'd2999, 8'd0},
    '{FMT_12, 14'd3000, 14'd3999, 8'd4}, '{FMT_12, 14'd4000, 14'd4999, 8'd0},
    '{FMT_12, 14'd5000, 14'd5999, 8'd3}, '{FMT_12, 14'd6000, 14'd9999, 8'd4},
    '{FMT_13, 14'd0, 14'd19, 8'd5}, '{FMT_13, 14'd20, 14'd29, 8'd0},
    '{FMT_13, 14'd30, 14'd39, 8'd5}, '{FMT_13, 14'd40, 14'd49, 8'd0},
    '{FMT_13, 14'd50, 14'd59, 8'd6}, '{FMT_13, 14'd60, 14'd139, 8'd5},
    '{FMT_13, 14'd200, 14'd299, 8'd0}, '{FMT_13, 14'd300, 14'd379, 8'd7},
    '{FMT_13, 14'd380, 14'd380, 8'd8}, '{FMT_13, 14'd381, 14'd381, 8'd9},
    '{FMT_13, 14'd383, 14'd383, 8'd10}, '{FMT_13, 14'd385, 14'd385, 8'd11},
    '{FMT_13, 14'd387, 14'd387, 8'd12}, '{FMT_13, 14'd389, 14'd389, 8'd13},
    '{FMT_13, 14'd450, 14'd459, 8'd14}, '{FMT_13, 14'd460, 14'd469, 8'd15},
    '{FMT_13, 14'd470, 14'd470, 8'd16}, '{FMT_13, 14'd471, 14'd471, 8'd17},
    '{FMT_13, 14'd472, 14'd472, 8'd18}, '{FMT_13, 14'd473, 14'd473, 8'd19},
    '{FMT_13, 14'd474, 14'd474, 8'd20}, '{FMT_13, 14'd475, 14'd475, 8'd21},
    '{FMT_13, 14'd476, 14'd476, 8'd22}, '{FMT_13, 14'd477, 14'd477, 8'd23},
    '{FMT_13, 14'd478, 14'd478, 8'd24}, '{FMT_13, 14'd479, 14'd479, 8'd25},
    '{FMT_13, 14'd480, 14'd480, 8'd26}, '{FMT_13, 14'd481, 14'd481, 8'd27},
    '{FMT_13, 14'd482, 14'd482, 8'd28}, '{FMT_13, 14'd483, 14'd483, 8'd29},
    '{FMT_13, 14'd484, 14'd484, 8'd30}, '{FMT_13, 14'd485, 14'd485, 8'd19},
    '{FMT_13, 14'd486, 14'd486, 8'd31}, '{FMT_13, 14'd487, 14'd487, 8'd32},
    '{FMT_13, 14'd488, 14'd488, 8'd33}, '{FMT_13, 14'd489, 14'd489, 8'd34},
    '{FMT_13, 14'd490, 14'd499, 8'd14}, '{FMT_13, 14'd500, 14'd509, 8'd35},
    '{FMT_13, 14'd520, 14'd521, 8'd36}, '{FMT_13, 14'd528, 14'd528, 8'd37},
    '{FMT_13, 14'd529, 14'd529, 8'd38}, '{FMT_13, 14'd530, 14'd530, 8'd39},
    '{FMT_13, 14'd531, 14'd531, 8'd40}, '{FMT_13, 14'd535, 14'd535, 8'd41},
    '{FMT_13, 14'd539, 14'd539, 8'd42}, '{FMT_13, 14'd540, 14'd549, 8'd43},
    '{FMT_13, 14'd560, 14'd560, 8'd44}, '{FMT_13, 14'd569, 14'd569, 8'd45},
    '{FMT_13, 14'd570, 14'd579, 8'd46}, '{FMT_13, 14'd590, 14'd590, 8'd47},
    '{FMT_13, 14'd594, 14'd594, 8'd48}, '{FMT_13, 14'd599, 14'd599, 8'd49},
    '{FMT_13, 14'd600, 14'd601, 8'd50}, '{FMT_13, 14'd603, 14'd603, 8'd51},
    '{FMT_13, 14'd604, 14'd604, 8'd52}, '{FMT_13, 14'd605, 14'd605, 8'd53},
    '{FMT_13, 14'd606, 14'd606, 8'd54}, '{FMT_13, 14'd607, 14'd607, 8'd55},
    '{FMT_13, 14'd608, 14'd608, 8'd56}, '{FMT_13, 14'd609, 14'd609, 8'd57},
    '{FMT_13, 14'd610, 14'd610, 8'd58}, '{FMT_13, 14'd611, 14'd611, 8'd59},
    '{FMT_13, 14'd613, 14'd613, 8'd60}, '{FMT_13, 14'd614, 14'd614, 8'd58},
    '{FMT_13, 14'd615, 14'd615, 8'd61}, '{FMT_13, 14'd616, 14'd616, 8'd62},
    '{FMT_13, 14'd617, 14'd617, 8'd63}, '{FMT_13, 14'd618, 14'd618, 8'd64},
    '{FMT_13, 14'd619, 14'd619, 8'd65}, '{FMT_13, 14'd620, 14'd620, 8'd66},
    '{FMT_13, 14'd621, 14'd621, 8'd67}, '{FMT_13, 14'd622, 14'd622, 8'd68},
    '{FMT_13, 14'd623, 14'd623, 8'd58}, '{FMT_13, 14'd624, 14'd624, 8'd69},
    '{FMT_13, 14'd625, 14'd625, 8'd70}, '{FMT_13, 14'd626, 14'd626, 8'd71},
    '{FMT_13, 14'd627, 14'd627, 8'd72}, '{FMT_13, 14'd628, 14'd628, 8'd73},
    '{FMT_13, 14'd629, 14'd629, 8'd74}, '{FMT_13, 14'd630, 14'd630, 8'd75},
    '{FMT_13, 14'd631, 14'd631, 8'd76}, '{FMT_13, 14'd632, 14'd632, 8'd77},
    '{FMT_13, 14'd640, 14'd649, 8'd78}, '{FMT_13, 14'd680, 14'd681, 8'd79},
    '{FMT_13, 14'd690, 14'd699, 8'd79}, '{FMT_13, 14'd700, 14'd709, 8'd80},
    '{FMT_13, 14'd729, 14'd729, 8'd81}, '{FMT_13, 14'd730, 14'd739, 8'd82},
    '{FMT_13, 14'd740, 14'd740, 8'd83}, '{FMT_13, 14'd741, 14'd741, 8'd84},
    '{FMT_13, 14'd742, 14'd742, 8'd85}, '{FMT_13, 14'd743, 14'd743, 8'd86},
    '{FMT_13, 14'd744, 14'd744, 8'd87}, '{FMT_13, 14'd745, 14'd745, 8'd88},
    '{FMT_13, 14'd746, 14'd746, 8'd89}, '{FMT_13, 14'd750, 14'd750, 8'd90},
    '{FMT_13, 14'd754, 14'd755, 8'd91}, '{FMT_13, 14'd758, 14'd758, 8'd58},
    '{FMT_13, 14'd759, 14'd759, 8'd92}, '{FMT_13, 14'd760, 14'd769, 8'd93},
    '{FMT_13, 14'd770, 14'd771, 8'd94}, '{FMT_13, 14'd773, 14'd773, 8'd95},
    '{FMT_13, 14'd775, 14'd775, 8'd96}, '{FMT_13, 14'd777, 14'd777, 8'd97},
    '{FMT_13, 14'd778, 14'd779, 8'd98}, '{FMT_13, 14'd780, 14'd780, 8'd99},
    '{FMT_13, 14'd784, 14'd784, 8'd100}, '{FMT_13, 14'd786, 14'd786, 8'd101},
    '{FMT_13, 14'd789, 14'd790, 8'd102}, '{FMT_13, 14'd800, 14'd839, 8'd103},
    '{FMT_13, 14'd840, 14'd849, 8'd104}, '{FMT_13, 14'd850, 14'd850, 8'd105},
    '{FMT_13, 14'd858, 14'd858, 8'd106}, '{FMT_13, 14'd859, 14'd859, 8'd107},
    '{FMT_13, 14'd860, 14'd860, 8'd108}, '{FMT_13, 14'd865, 14'd865, 8'd109},
    '{FMT_13, 14'd867, 14'd867, 8'd110}, '{FMT_13, 14'd868, 14'd869, 8'd111},
    '{FMT_13, 14'd870, 14'd879, 8'd112}, '{FMT_13, 14'd880, 14'd881, 8'd113},
    '{FMT_13, 14'd883, 14'd883, 8'd114}, '{FMT_13, 14'd884, 14'd884, 8'd115},
    '{FMT_13, 14'd887, 14'd887, 8'd116}, '{FMT_13, 14'd885, 14'd885, 8'd117},
    '{FMT_13, 14'd888, 14'd888, 8'd118}, '{FMT_13, 14'd890, 14'd890, 8'd119},
    '{FMT_13, 14'd893, 14'd893, 8'd18}, '{FMT_13, 14'd894, 14'd894, 8'd58},
    '{FMT_13, 14'd896, 14'd896, 8'd120}, '{FMT_13, 14'd899, 14'd899, 8'd121},
    '{FMT_13, 14'd900, 14'd919, 8'd122}, '{FMT_13, 14'd930, 14'd939, 8'd123},
    '{FMT_13, 14'd940, 14'd949, 8'd124}, '{FMT_13, 14'd951, 14'd951, 8'd58},
    '{FMT_13, 14'd952, 14'd952, 8'd2}, '{FMT_13, 14'd955, 14'd955, 8'd125},
    '{FMT_13, 14'd958, 14'd958, 8'd126}, '{FMT_13, 14'd959, 14'd959, 8'd127},
    '{FMT_13, 14'd960, 14'd969, 8'd58}, '{FMT_13, 14'd977, 14'd977, 8'd128},
    '{FMT_13, 14'd978, 14'd979, 8'd129}, '{FMT_13, 14'd980, 14'd980, 8'd130},
    '{FMT_13, 14'd981, 14'd983, 8'd131}, '{FMT_13, 14'd984, 14'd989, 8'd132},
    '{FMT_13, 14'd990, 14'd999, 8'd131}
  };

endpackage

/* sv/gtin_digit_string_validator_core.sv */
// Top level: GTIN digit string validator with mod-10 check and prefix class lookup.
//
//   channel  direction  handshake            payload
//   in       request in in_valid / in_stall  character, is_last
//   out      result out out_valid / out_stall status, format, calc_digit,
//                                             range_value, prefix_class
//
// One character is taken every cycle while in does not stall; the result of a string
// moves through the stage registers into the output register and leaves it once out
// does not stall.
// Stages: input register, accumulator snapshot, length/format/sum, mod-10 and
// range compare, class select into the output register.
// Reset (rst, synchronous) empties all stages and clears the string state.
// A stall on out holds the stages back; in stalls only when every stage is full.
`include "gtin_digit_string_validator_core_assert.svh"

module gtin_digit_string_validator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  format,
  output logic [3:0]  calc_digit,
  output logic [13:0] range_value,
  output logic [7:0]  prefix_class
);

  localparam int MD = gtin_pkg::MAX_DIGITS;
  localparam int NS = gtin_pkg::N_SPANS;

  // Stage 0: input register
  logic        v0;
  logic [7:0]  ch0;
  logic        last0;
  // Stage 1: string snapshot
  logic            v1;
  gtin_pkg::snap_t s1;
  gtin_pkg::snap_t snap;
  // Stage 2: format, sums, prefix digits
  logic                v2;
  gtin_pkg::status_t   st2;
  logic [1:0]          fmt2;
  gtin_pkg::digit_t    ld2;
  logic [8:0]          sum2;
  logic [13:0]         pv2;
  logic [1:0]          tsel2;
  // Stage 3: check result and range matches
  logic                v3;
  gtin_pkg::status_t   st3;
  logic [1:0]          fmt3;
  logic [3:0]          cd3;
  logic [13:0]         pv3;
  logic [NS-1:0]       match3;
  // Output register
  gtin_pkg::status_t   st4;

  logic r0, r1, r2, r3, r4, adv0;

  // Stage-2 combinational
  gtin_pkg::digit_t [MD-1:0] pd;
  logic [gtin_pkg::CNT_W-1:0] len_m1;
  logic                len_ok;
  gtin_pkg::status_t   st2_next;
  logic [1:0]          fmt2_next;
  gtin_pkg::digit_t    ld2_next;
  logic [gtin_pkg::SUM_W-1:0] w3, w1;
  logic [8:0]          sum2_next;
  gtin_pkg::digit_t    pa, pb, pc, pe;
  logic [13:0]         pv2_next;
  logic [1:0]          tsel2_next;

  // Stage-3 combinational
  logic [17:0]         quo_full;
  logic [5:0]          quo;
  logic [3:0]          rem;
  logic [3:0]          cd_calc;
  gtin_pkg::status_t   st3_next;
  logic [1:0]          fmt3_next;
  logic [3:0]          cd3_next;
  logic [13:0]         pv3_next;
  logic [NS-1:0]       match3_next;

  // Output combinational
  logic [7:0]          cls_or;

  // Ready chain from the output back to the input register
  assign r4   = !out_valid || !out_stall;
  assign r3   = !v3 || r4;
  assign r2   = !v2 || r3;
  assign r1   = !v1 || r2;
  assign adv0 = v0 && (!last0 || r1);
  assign r0   = !v0 || adv0;
  assign in_stall = !r0;

  gtin_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .upd       (adv0),
    .character (ch0),
    .is_last   (last0),
    .snap      (snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r0) begin
        v0 <= in_valid;
      end
      if (r1) begin
        v1 <= adv0 && last0;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        out_valid <= v3;
      end
    end
  end

  // Stage 2: left-pad to fourteen digits, classify, weighted sum
  assign len_m1 = s1.cnt - 1'b1;
  assign len_ok = (s1.cnt == 4'd8) || (s1.cnt == 4'd12) || (s1.cnt == 4'd13) ||
                  (s1.cnt == 4'd14);

  always_comb begin
    pd = '0;
    case (s1.cnt)
      4'd8: begin
        for (int i = 6; i < MD; i++) begin
          pd[i] = s1.digits[i-6];
        end
      end
      4'd12: begin
        for (int i = 2; i < MD; i++) begin
          pd[i] = s1.digits[i-2];
        end
      end
      4'd13: begin
        for (int i = 1; i < MD; i++) begin
          pd[i] = s1.digits[i-1];
        end
      end
      default: begin
        pd = s1.digits;
      end
    endcase
  end

  always_comb begin
    case (s1.cnt)
      4'd8:  fmt2_next = gtin_pkg::FMT_8;
      4'd12: fmt2_next = gtin_pkg::FMT_12;
      4'd13: fmt2_next = gtin_pkg::FMT_13;
      default: begin
        // Fourteen digits: leading zeros reclassify the code
        if ((pd[0] == '0) && (pd[1] == '0) && (pd[2] == '0) && (pd[3] == '0) &&
            (pd[4] == '0) && (pd[5] == '0)) begin
          fmt2_next = gtin_pkg::FMT_8;
        end else if ((pd[0] == '0) && (pd[1] == '0)) begin
          fmt2_next = gtin_pkg::FMT_12;
        end else if (s1.digits[0] == '0) begin
          fmt2_next = gtin_pkg::FMT_13;
        end else begin
          fmt2_next = gtin_pkg::FMT_14;
        end
      end
    endcase
  end

  always_comb begin
    if (s1.bad) begin
      st2_next = gtin_pkg::ST_BAD_CHAR;
    end else if (!len_ok) begin
      st2_next = gtin_pkg::ST_BAD_LEN;
    end else begin
      st2_next = gtin_pkg::ST_OK;
    end
    ld2_next = len_ok ? s1.digits[len_m1] : '0;
    if (s1.cnt[0]) begin
      w3 = s1.odd_sum;
      w1 = s1.even_sum - gtin_pkg::SUM_W'(ld2_next);
    end else begin
      w3 = s1.even_sum;
      w1 = s1.odd_sum - gtin_pkg::SUM_W'(ld2_next);
    end
    sum2_next = 9'(w3) * 9'd3 + 9'(w1);
    case (fmt2_next)
      gtin_pkg::FMT_8: begin
        pa = '0;    pb = pd[6]; pc = pd[7]; pe = pd[8];
        tsel2_next = gtin_pkg::FMT_8;
      end
      gtin_pkg::FMT_12: begin
        pa = pd[2]; pb = pd[3]; pc = pd[4]; pe = pd[5];
        tsel2_next = gtin_pkg::FMT_12;
      end
      default: begin
        pa = '0;    pb = pd[1]; pc = pd[2]; pe = pd[3];
        tsel2_next = gtin_pkg::FMT_13;
      end
    endcase
    pv2_next = 14'(pa) * 14'd1000 + 14'(pb) * 14'd100 + 14'(pc) * 14'd10 + 14'(pe);
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      st2   <= st2_next;
      fmt2  <= fmt2_next;
      ld2   <= ld2_next;
      sum2  <= sum2_next;
      pv2   <= pv2_next;
      tsel2 <= tsel2_next;
    end
    if (r1) begin
      s1 <= snap;
    end
    if (r0 && in_valid) begin
      ch0   <= character;
      last0 <= is_last;
    end
  end

  // Stage 3: sum mod 10 by reciprocal, check compare, range compares
  always_comb begin
    quo_full = 18'(sum2) * 18'd205;
    quo      = quo_full[16:11];
    rem      = 4'(sum2 - 9'(quo) * 9'd10);
    cd_calc  = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;
    if (st2 != gtin_pkg::ST_OK) begin
      st3_next  = st2;
      fmt3_next = gtin_pkg::FMT_8;
      cd3_next  = '0;
      pv3_next  = '0;
    end else if (cd_calc != ld2) begin
      st3_next  = gtin_pkg::ST_BAD_CHECK;
      fmt3_next = fmt2;
      cd3_next  = '0;
      pv3_next  = '0;
    end else begin
      st3_next  = gtin_pkg::ST_OK;
      fmt3_next = fmt2;
      cd3_next  = cd_calc;
      pv3_next  = pv2;
    end
    for (int i = 0; i < NS; i++) begin
      match3_next[i] = (gtin_pkg::SPANS[i].tbl == tsel2) &&
                       (pv2 >= gtin_pkg::SPANS[i].lo) && (pv2 <= gtin_pkg::SPANS[i].hi);
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      st3    <= st3_next;
      fmt3   <= fmt3_next;
      cd3    <= cd3_next;
      pv3    <= pv3_next;
      match3 <= match3_next;
    end
  end

  // Output: ranges never overlap, so OR the matching class
  always_comb begin
    cls_or = '0;
    for (int i = 0; i < NS; i++) begin
      cls_or = cls_or | (match3[i] ? gtin_pkg::SPANS[i].cls : 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      st4          <= st3;
      format       <= fmt3;
      calc_digit   <= cd3;
      range_value  <= pv3;
      prefix_class <= ((st3 == gtin_pkg::ST_OK) && (|match3)) ? cls_or : gtin_pkg::NOT_FOUND;
    end
  end

  assign status = st4;

  `GTIN_ASSERT_NOW(a_err_fields, out_valid && (status != gtin_pkg::ST_OK), (prefix_class == gtin_pkg::NOT_FOUND) && (calc_digit == 4'd0) && (range_value == 14'd0), "error result carries nonzero fields")
  `GTIN_ASSERT_NOW(a_err_format, out_valid && ((status == gtin_pkg::ST_BAD_CHAR) || (status == gtin_pkg::ST_BAD_LEN)), format == gtin_pkg::FMT_8, "format not cleared on input error")
  `GTIN_ASSERT_NOW(a_stall_full, in_stall, v0 && last0 && v1 && v2 && v3 && out_valid && out_stall, "input stalled with a free stage")

endmodule

/* sv/gtin_acc.sv */
// Per-character accumulator: digit store, length count, bad-character flag, digit sums.
`include "gtin_digit_string_validator_core_assert.svh"

module gtin_acc (
  input  logic                clk,
  input  logic                rst,
  input  logic                upd,
  input  logic [7:0]          character,
  input  logic                is_last,
  output gtin_pkg::snap_t     snap
);

  gtin_pkg::digit_t               digit_store [gtin_pkg::MAX_DIGITS];
  logic [gtin_pkg::CNT_W-1:0]     cnt;
  logic                           bad;
  logic [gtin_pkg::SUM_W-1:0]     even_sum;
  logic [gtin_pkg::SUM_W-1:0]     odd_sum;

  logic                           is_digit;
  logic                           store_en;
  gtin_pkg::digit_t               dig;

  assign is_digit = (character >= gtin_pkg::CHAR_ZERO) && (character <= gtin_pkg::CHAR_NINE);
  assign dig      = gtin_pkg::digit_t'(character - gtin_pkg::CHAR_ZERO);
  assign store_en = is_digit && (cnt < gtin_pkg::CNT_W'(gtin_pkg::MAX_DIGITS));

  // Fold the current character into the running state.
  always_comb begin
    for (int i = 0; i < gtin_pkg::MAX_DIGITS; i++) begin
      if (store_en && (cnt == gtin_pkg::CNT_W'(i))) begin
        snap.digits[i] = dig;
      end else begin
        snap.digits[i] = digit_store[i];
      end
    end
    snap.cnt      = (cnt == gtin_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
    snap.bad      = bad | ~is_digit;
    snap.even_sum = even_sum;
    snap.odd_sum  = odd_sum;
    if (store_en && !cnt[0]) begin
      snap.even_sum = even_sum + gtin_pkg::SUM_W'(dig);
    end
    if (store_en && cnt[0]) begin
      snap.odd_sum = odd_sum + gtin_pkg::SUM_W'(dig);
    end
  end

  always_ff @(posedge clk) begin
    if (upd && store_en) begin
      digit_store[cnt] <= dig;
    end
  end

  // Fold each character into the string state; drop the state after its last character.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      bad      <= 1'b0;
      even_sum <= '0;
      odd_sum  <= '0;
    end else if (upd) begin
      if (is_last) begin
        cnt      <= '0;
        bad      <= 1'b0;
        even_sum <= '0;
        odd_sum  <= '0;
      end else begin
        cnt      <= snap.cnt;
        bad      <= snap.bad;
        even_sum <= snap.even_sum;
        odd_sum  <= snap.odd_sum;
      end
    end
  end

  `GTIN_ASSERT_NEXT(a_clear_after_last, upd && is_last, (cnt == '0) && !bad && (even_sum == '0) && (odd_sum == '0), "string state not cleared after last character")
  `GTIN_ASSERT_NEXT(a_count_step, upd && !is_last && (cnt != gtin_pkg::CNT_MAX), cnt == $past(cnt) + 1'b1, "character count did not advance")
  `GTIN_ASSERT_NEXT(a_bad_sticky, upd && !is_last && !is_digit, bad, "non-digit not recorded")

endmodule
